/* src/assert_macros.svh */
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define AWCM_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked during reset.
`define AWCM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication, checked through reset as well.
`define AWCM_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

/* src/awcm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADC window average current monitor package
// Widths, constants, codes and shared types of the monitor.
// ----------------------------------------------------------------------------
package awcm_pkg;

   // sample ring
   localparam int AVG_DEPTH = 64;
   localparam int IDX_W     = $clog2(AVG_DEPTH);
   localparam int CNT_W     = $clog2(AVG_DEPTH + 1);

   // input word layout
   localparam int WORD_W   = 16;
   localparam int ERR_BIT  = 15;
   localparam int SAMPLE_W = 12;

   // window sum, including the rounding half
   localparam int SUM_MAX = AVG_DEPTH * ((1 << SAMPLE_W) - 1) + AVG_DEPTH / 2;
   localparam int SUM_W   = $clog2(SUM_MAX + 1);
   localparam int STEP_W  = $clog2(SUM_W + 1);

   // scaling: mv = (avg*3300+2048)>>12, ma = (mv*7447+4096)>>13
   localparam int REF_MV    = 3300;
   localparam int RAW_SHIFT = 12;
   localparam int MA_MUL    = 7447;
   localparam int MA_SHIFT  = 13;
   localparam int MV_W      = 12;
   localparam int MA_W      = 12;
   localparam int MV_PROD_W = 24;
   localparam int MA_PROD_W = 25;

   localparam int ERRCNT_W = 32;

   // front queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // configuration registers
   localparam int CSR_IDX_W = 2;
   localparam int WIN_W     = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_WINDOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_WINDOW  = 2'd1;
   localparam logic [WIN_W-1:0]     SHORT_WIN_RESET  = 7'd8;
   localparam logic [WIN_W-1:0]     LONG_WIN_RESET   = 7'd64;

   typedef struct packed {
      logic                err;
      logic [SAMPLE_W-1:0] value;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } fe_out_type;

   typedef struct packed {
      logic                 valid;
      logic [CSR_IDX_W-1:0] index;
      logic [WIN_W-1:0]     data;
   } csr_wr_type;

   typedef struct packed {
      logic                done;
      logic [SAMPLE_W-1:0] quotient;
   } div_rsp_type;

   // zero reads as one sample, anything past the ring as the whole ring
   function automatic logic [CNT_W-1:0] clamp_window(input logic [WIN_W-1:0] w);
      logic [CNT_W-1:0] n;
      if (w == '0) begin
         n = CNT_W'(1);
      end else if (int'(w) > AVG_DEPTH) begin
         n = CNT_W'(AVG_DEPTH);
      end else begin
         n = CNT_W'(w);
      end
      return n;
   endfunction

endpackage

/* src/awcm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Monitor front end
// Accepts ADC words, splits off the error flag and the conversion value,
// and queues them for the back end.
// ----------------------------------------------------------------------------
module awcm_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [awcm_pkg::WORD_W-1:0] req_sample_word,
   input  logic                       item_pop,
   output awcm_pkg::fe_out_type       fe_out
);

   awcm_pkg::item_type            queue_ff [awcm_pkg::QUEUE_DEPTH];
   awcm_pkg::item_type            new_item;
   logic [awcm_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [awcm_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [awcm_pkg::QCNT_W-1:0]   count_ff, count_in;
   logic                          do_push;
   logic                          do_pop;

   assign req_full = (count_ff == awcm_pkg::QCNT_W'(awcm_pkg::QUEUE_DEPTH));
   assign do_push  = req_push && !req_full;
   assign do_pop   = item_pop && (count_ff != '0);

   assign new_item.err   = req_sample_word[awcm_pkg::ERR_BIT];
   assign new_item.value = req_sample_word[awcm_pkg::SAMPLE_W-1:0];

   assign fe_out.valid = (count_ff != '0);
   assign fe_out.item  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == awcm_pkg::QPTR_W'(awcm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == awcm_pkg::QPTR_W'(awcm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

/* src/awcm_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window average divider
// Restoring divider, one quotient bit per cycle, for sum over sample count.
// ----------------------------------------------------------------------------
module awcm_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [awcm_pkg::SUM_W-1:0] dividend,
   input  logic [awcm_pkg::CNT_W-1:0] divisor,
   output awcm_pkg::div_rsp_type      div_rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [awcm_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [awcm_pkg::CNT_W-1:0]    rem_ff, rem_in;
   logic [awcm_pkg::SUM_W-1:0]    dvd_ff, dvd_in;
   logic [awcm_pkg::CNT_W-1:0]    dsr_ff, dsr_in;
   logic [awcm_pkg::CNT_W:0]      rem_sh;
   logic [awcm_pkg::CNT_W:0]      rem_sub;
   logic                          fits;

   assign rem_sh  = {rem_ff, dvd_ff[awcm_pkg::SUM_W-1]};
   assign rem_sub = rem_sh - {1'b0, dsr_ff};
   assign fits    = (rem_sh >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // shift the quotient bit in where the dividend bit left
         rem_in  = fits ? rem_sub[awcm_pkg::CNT_W-1:0] : rem_sh[awcm_pkg::CNT_W-1:0];
         dvd_in  = {dvd_ff[awcm_pkg::SUM_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == awcm_pkg::STEP_W'(awcm_pkg::SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dvd_ff[awcm_pkg::SAMPLE_W-1:0];

endmodule

/* src/awcm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Monitor back end
// Stores each sample in the ring, sums both windows, divides, scales to
// milliamps and holds the result for the consumer.
// ----------------------------------------------------------------------------
module awcm_back (
   input  logic                          clock,
   input  logic                          reset,
   input  awcm_pkg::fe_out_type          fe_out,
   output logic                          item_pop,
   input  awcm_pkg::csr_wr_type          csr_wr,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [awcm_pkg::MA_W-1:0]     rsp_short_milliamps,
   output logic [awcm_pkg::MA_W-1:0]     rsp_long_milliamps,
   output logic [awcm_pkg::ERRCNT_W-1:0] rsp_error_count
);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_SUM   = 9'b000000010,
      ST_DIVS  = 9'b000000100,
      ST_WAITS = 9'b000001000,
      ST_DIVL  = 9'b000010000,
      ST_WAITL = 9'b000100000,
      ST_MV    = 9'b001000000,
      ST_MA    = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   state_type                         state_ff, state_in;

   logic [awcm_pkg::SAMPLE_W-1:0]     ring_mem [awcm_pkg::AVG_DEPTH];
   logic [awcm_pkg::AVG_DEPTH-1:0]    ring_vld_ff, ring_vld_in;
   logic                              mem_we;
   logic [awcm_pkg::SAMPLE_W-1:0]     rd_data_ff;
   logic                              rd_vld_ff, rd_vld_in;

   logic [awcm_pkg::IDX_W-1:0]        wp_ff, wp_in;
   logic [awcm_pkg::IDX_W-1:0]        rd_idx_ff, rd_idx_in;
   logic [awcm_pkg::ERRCNT_W-1:0]     err_cnt_ff, err_cnt_in;
   logic [awcm_pkg::WIN_W-1:0]        short_win_ff, short_win_in;
   logic [awcm_pkg::WIN_W-1:0]        long_win_ff, long_win_in;
   logic [awcm_pkg::CNT_W-1:0]        n_s_ff, n_s_in;
   logic [awcm_pkg::CNT_W-1:0]        n_l_ff, n_l_in;
   logic [awcm_pkg::CNT_W-1:0]        n_max_ff, n_max_in;
   logic [awcm_pkg::CNT_W-1:0]        iss_ff, iss_in;
   logic                              rd_en_ff, rd_en_in;
   logic [awcm_pkg::CNT_W-1:0]        rd_j_ff, rd_j_in;
   logic [awcm_pkg::SUM_W-1:0]        sum_s_ff, sum_s_in;
   logic [awcm_pkg::SUM_W-1:0]        sum_l_ff, sum_l_in;
   logic [awcm_pkg::SAMPLE_W-1:0]     avg_s_ff, avg_s_in;
   logic [awcm_pkg::SAMPLE_W-1:0]     avg_l_ff, avg_l_in;
   logic [awcm_pkg::MV_W-1:0]         mv_s_ff, mv_s_in;
   logic [awcm_pkg::MV_W-1:0]         mv_l_ff, mv_l_in;
   logic [awcm_pkg::MA_W-1:0]         ma_s_ff, ma_s_in;
   logic [awcm_pkg::MA_W-1:0]         ma_l_ff, ma_l_in;
   logic                              out_vld_ff, out_vld_in;
   logic [awcm_pkg::MA_W-1:0]         out_s_ff, out_s_in;
   logic [awcm_pkg::MA_W-1:0]         out_l_ff, out_l_in;
   logic [awcm_pkg::ERRCNT_W-1:0]     out_err_ff, out_err_in;

   logic                              div_start;
   logic [awcm_pkg::SUM_W-1:0]        div_dividend;
   logic [awcm_pkg::CNT_W-1:0]        div_divisor;
   awcm_pkg::div_rsp_type             div_rsp;

   logic [awcm_pkg::SUM_W-1:0]        addend;
   logic [awcm_pkg::CNT_W-1:0]        n_s_new;
   logic [awcm_pkg::CNT_W-1:0]        n_l_new;
   logic                              out_free;
   logic [awcm_pkg::MV_PROD_W-1:0]    mv_prod_s, mv_prod_l;
   logic [awcm_pkg::MA_PROD_W-1:0]    ma_prod_s, ma_prod_l;

   awcm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .div_rsp  (div_rsp)
   );

   assign addend   = rd_vld_ff ? awcm_pkg::SUM_W'(rd_data_ff) : '0;
   assign n_s_new  = awcm_pkg::clamp_window(short_win_ff);
   assign n_l_new  = awcm_pkg::clamp_window(long_win_ff);
   assign out_free = !out_vld_ff || rsp_pop;
   assign rd_vld_in = ring_vld_ff[rd_idx_ff];

   assign mv_prod_s = awcm_pkg::MV_PROD_W'(avg_s_ff) * awcm_pkg::MV_PROD_W'(awcm_pkg::REF_MV)
                    + awcm_pkg::MV_PROD_W'(1 << (awcm_pkg::RAW_SHIFT - 1));
   assign mv_prod_l = awcm_pkg::MV_PROD_W'(avg_l_ff) * awcm_pkg::MV_PROD_W'(awcm_pkg::REF_MV)
                    + awcm_pkg::MV_PROD_W'(1 << (awcm_pkg::RAW_SHIFT - 1));
   assign ma_prod_s = awcm_pkg::MA_PROD_W'(mv_s_ff) * awcm_pkg::MA_PROD_W'(awcm_pkg::MA_MUL)
                    + awcm_pkg::MA_PROD_W'(1 << (awcm_pkg::MA_SHIFT - 1));
   assign ma_prod_l = awcm_pkg::MA_PROD_W'(mv_l_ff) * awcm_pkg::MA_PROD_W'(awcm_pkg::MA_MUL)
                    + awcm_pkg::MA_PROD_W'(1 << (awcm_pkg::MA_SHIFT - 1));

   always_comb begin
      state_in     = state_ff;
      ring_vld_in  = ring_vld_ff;
      mem_we       = 1'b0;
      item_pop     = 1'b0;
      wp_in        = wp_ff;
      rd_idx_in    = rd_idx_ff;
      err_cnt_in   = err_cnt_ff;
      short_win_in = short_win_ff;
      long_win_in  = long_win_ff;
      n_s_in       = n_s_ff;
      n_l_in       = n_l_ff;
      n_max_in     = n_max_ff;
      iss_in       = iss_ff;
      rd_en_in     = 1'b0;
      rd_j_in      = rd_j_ff;
      sum_s_in     = sum_s_ff;
      sum_l_in     = sum_l_ff;
      avg_s_in     = avg_s_ff;
      avg_l_in     = avg_l_ff;
      mv_s_in      = mv_s_ff;
      mv_l_in      = mv_l_ff;
      ma_s_in      = ma_s_ff;
      ma_l_in      = ma_l_ff;
      out_vld_in   = out_vld_ff;
      out_s_in     = out_s_ff;
      out_l_in     = out_l_ff;
      out_err_in   = out_err_ff;
      div_start    = 1'b0;
      div_dividend = sum_s_ff + awcm_pkg::SUM_W'(n_s_ff >> 1);
      div_divisor  = n_s_ff;

      if (csr_wr.valid) begin
         unique case (csr_wr.index)
            awcm_pkg::CSR_SHORT_WINDOW: short_win_in = csr_wr.data;
            awcm_pkg::CSR_LONG_WINDOW:  long_win_in  = csr_wr.data;
            default: ;
         endcase
      end

      if (rsp_pop && out_vld_ff) begin
         out_vld_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (fe_out.valid) begin
               item_pop    = 1'b1;
               mem_we      = 1'b1;
               ring_vld_in[wp_ff] = 1'b1;
               err_cnt_in  = err_cnt_ff + awcm_pkg::ERRCNT_W'(fe_out.item.err);
               rd_idx_in   = wp_ff;
               wp_in       = (wp_ff == awcm_pkg::IDX_W'(awcm_pkg::AVG_DEPTH - 1)) ?
                             '0 : wp_ff + 1'b1;
               n_s_in      = n_s_new;
               n_l_in      = n_l_new;
               n_max_in    = (n_l_new > n_s_new) ? n_l_new : n_s_new;
               iss_in      = '0;
               sum_s_in    = '0;
               sum_l_in    = '0;
               state_in    = ST_SUM;
            end
         end
         ST_SUM: begin
            // walk back from the newest sample, one read per cycle
            if (iss_ff < n_max_ff) begin
               rd_en_in  = 1'b1;
               rd_j_in   = iss_ff;
               iss_in    = iss_ff + 1'b1;
               rd_idx_in = (rd_idx_ff == '0) ?
                           awcm_pkg::IDX_W'(awcm_pkg::AVG_DEPTH - 1) : rd_idx_ff - 1'b1;
            end
            if (rd_en_ff) begin
               if (rd_j_ff < n_s_ff) begin
                  sum_s_in = sum_s_ff + addend;
               end
               if (rd_j_ff < n_l_ff) begin
                  sum_l_in = sum_l_ff + addend;
               end
               if (rd_j_ff == n_max_ff - 1'b1) begin
                  state_in = ST_DIVS;
               end
            end
         end
         ST_DIVS: begin
            div_start = 1'b1;
            state_in  = ST_WAITS;
         end
         ST_WAITS: begin
            if (div_rsp.done) begin
               avg_s_in = div_rsp.quotient;
               state_in = ST_DIVL;
            end
         end
         ST_DIVL: begin
            div_start    = 1'b1;
            div_dividend = sum_l_ff + awcm_pkg::SUM_W'(n_l_ff >> 1);
            div_divisor  = n_l_ff;
            state_in     = ST_WAITL;
         end
         ST_WAITL: begin
            if (div_rsp.done) begin
               avg_l_in = div_rsp.quotient;
               state_in = ST_MV;
            end
         end
         ST_MV: begin
            mv_s_in  = mv_prod_s[awcm_pkg::RAW_SHIFT +: awcm_pkg::MV_W];
            mv_l_in  = mv_prod_l[awcm_pkg::RAW_SHIFT +: awcm_pkg::MV_W];
            state_in = ST_MA;
         end
         ST_MA: begin
            ma_s_in  = ma_prod_s[awcm_pkg::MA_SHIFT +: awcm_pkg::MA_W];
            ma_l_in  = ma_prod_l[awcm_pkg::MA_SHIFT +: awcm_pkg::MA_W];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the result register frees up
            if (out_free) begin
               out_vld_in = 1'b1;
               out_s_in   = ma_s_ff;
               out_l_in   = ma_l_ff;
               out_err_in = err_cnt_ff;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ring_vld_ff  <= '0;
         wp_ff        <= '0;
         err_cnt_ff   <= '0;
         short_win_ff <= awcm_pkg::SHORT_WIN_RESET;
         long_win_ff  <= awcm_pkg::LONG_WIN_RESET;
         rd_en_ff     <= 1'b0;
         out_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ring_vld_ff  <= ring_vld_in;
         wp_ff        <= wp_in;
         err_cnt_ff   <= err_cnt_in;
         short_win_ff <= short_win_in;
         long_win_ff  <= long_win_in;
         rd_en_ff     <= rd_en_in;
         out_vld_ff   <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff  <= rd_idx_in;
      n_s_ff     <= n_s_in;
      n_l_ff     <= n_l_in;
      n_max_ff   <= n_max_in;
      iss_ff     <= iss_in;
      rd_j_ff    <= rd_j_in;
      rd_vld_ff  <= rd_vld_in;
      sum_s_ff   <= sum_s_in;
      sum_l_ff   <= sum_l_in;
      avg_s_ff   <= avg_s_in;
      avg_l_ff   <= avg_l_in;
      mv_s_ff    <= mv_s_in;
      mv_l_ff    <= mv_l_in;
      ma_s_ff    <= ma_s_in;
      ma_l_ff    <= ma_l_in;
      out_s_ff   <= out_s_in;
      out_l_ff   <= out_l_in;
      out_err_ff <= out_err_in;
   end

   // sample ring: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[wp_ff] <= fe_out.item.value;
      end
      if (rd_en_in) begin
         rd_data_ff <= ring_mem[rd_idx_ff];
      end
   end

   assign rsp_empty           = !out_vld_ff;
   assign rsp_short_milliamps = out_s_ff;
   assign rsp_long_milliamps  = out_l_ff;
   assign rsp_error_count     = out_err_ff;

endmodule

/* src/adc_window_average_current_monitor.sv */
`timescale 1ns / 1ps
// Per sample: the back end walks the ring over the newest n samples, n = larger
//   of the two clamped windows, runs two divisions, scales and holds the result.
// Flow: one sample at a time, paced by the one-read-per-cycle ring walk and
//   the two 18-step divisions; two more samples may wait in the queue.
// Reset: synchronous; clears the ring valid bits, error count and queues and
//   sets the windows to 8 and 64. No clearing pass is needed.
// ----------------------------------------------------------------------------
// ADC window average current monitor
// Short and long moving averages of ADC samples, converted to milliamps,
// with a count of error-flagged conversions.
// ----------------------------------------------------------------------------
module adc_window_average_current_monitor (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [awcm_pkg::WORD_W-1:0]       req_sample_word,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [awcm_pkg::MA_W-1:0]         rsp_short_milliamps,
   output logic [awcm_pkg::MA_W-1:0]         rsp_long_milliamps,
   output logic [awcm_pkg::ERRCNT_W-1:0]     rsp_error_count,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [awcm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [awcm_pkg::WIN_W-1:0]        csr_data
);

   awcm_pkg::fe_out_type fe_out;
   awcm_pkg::csr_wr_type csr_wr;
   logic                 item_pop;

   assign csr_ready    = 1'b1;
   assign csr_wr.valid = csr_valid;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_data;

   awcm_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_sample_word (req_sample_word),
      .item_pop        (item_pop),
      .fe_out          (fe_out)
   );

   awcm_back u_back (
      .clock               (clock),
      .reset               (reset),
      .fe_out              (fe_out),
      .item_pop            (item_pop),
      .csr_wr              (csr_wr),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_short_milliamps (rsp_short_milliamps),
      .rsp_long_milliamps  (rsp_long_milliamps),
      .rsp_error_count     (rsp_error_count)
   );

endmodule

/* src/awcm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Monitor port checker
// Watches the top-level ports for result hold, reset state and value range.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module awcm_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_full,
   input logic                              rsp_empty,
   input logic                              rsp_pop,
   input logic [awcm_pkg::MA_W-1:0]         rsp_short_milliamps,
   input logic [awcm_pkg::MA_W-1:0]         rsp_long_milliamps,
   input logic [awcm_pkg::ERRCNT_W-1:0]     rsp_error_count
);

   `AWCM_ASSERT_NEXT(a_rsp_hold, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_short_milliamps) && $stable(rsp_long_milliamps) && $stable(rsp_error_count), "result changed before pop")
   `AWCM_ASSERT_NEXT_ALWAYS(a_reset_state, reset, rsp_empty && !req_full, "queues not empty after reset")
   `AWCM_ASSERT_IMPL(a_ma_range, !rsp_empty, (rsp_short_milliamps <= 12'd2999) && (rsp_long_milliamps <= 12'd2999), "current out of range")

endmodule

bind adc_window_average_current_monitor awcm_checker u_awcm_checker (
   .clock               (clock),
   .reset               (reset),
   .req_full            (req_full),
   .rsp_empty           (rsp_empty),
   .rsp_pop             (rsp_pop),
   .rsp_short_milliamps (rsp_short_milliamps),
   .rsp_long_milliamps  (rsp_long_milliamps),
   .rsp_error_count     (rsp_error_count)
);

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Current monitor testbench
// Drives ADC words through the monitor with random gaps on both sides,
// predicts both window currents and the error count for every accepted
// request, and compares each popped reading with the oldest expected reading.
// ----------------------------------------------------------------------------
module tb;

   localparam int HALF_PERIOD    = 2;
   localparam int RESET_CYCLES   = 12;
   localparam int MAX_LATENCY    = awcm_pkg::AVG_DEPTH + 45;
   localparam int RANDOM_PHASES  = 16;
   localparam int PHASE_SAMPLES  = 96;
   localparam int HOLD_PHASE     = 3;
   localparam int RX_HOLD_CYCLES = 600;
   localparam int REPORT_LIMIT   = 10;
   localparam int LIMIT_CYCLES   = 1_000_000;
   localparam int SCRIPT_LEN     = 25;
   localparam int SCRIPT_PHASES  = 5;

   // indexes past the register list; the block must ignore writes to them
   localparam logic [awcm_pkg::CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [awcm_pkg::CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct packed {
      logic [awcm_pkg::MA_W-1:0]     short_current;
      logic [awcm_pkg::MA_W-1:0]     long_current;
      logic [awcm_pkg::ERRCNT_W-1:0] errors;
   } current_reading_type;

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type                   kind;
      logic [awcm_pkg::CSR_IDX_W-1:0] index;
      logic [awcm_pkg::WORD_W-1:0]    value;
      logic                           typed;
      current_reading_type            want;
   } stim_row_type;

   localparam current_reading_type NO_READING = '0;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_push = 1'b0;
   logic                           req_full;
   logic [awcm_pkg::WORD_W-1:0]    req_sample_word = '0;
   logic                           rsp_empty;
   logic                           rsp_pop = 1'b0;
   logic [awcm_pkg::MA_W-1:0]      rsp_short_milliamps;
   logic [awcm_pkg::MA_W-1:0]      rsp_long_milliamps;
   logic [awcm_pkg::ERRCNT_W-1:0]  rsp_error_count;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [awcm_pkg::CSR_IDX_W-1:0] csr_index = awcm_pkg::CSR_SHORT_WINDOW;
   logic [awcm_pkg::WIN_W-1:0]     csr_data = '0;

   adc_window_average_current_monitor uut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_sample_word     (req_sample_word),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_short_milliamps (rsp_short_milliamps),
      .rsp_long_milliamps  (rsp_long_milliamps),
      .rsp_error_count     (rsp_error_count),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // shadow state of the monitor
   logic [awcm_pkg::SAMPLE_W-1:0] ring_model [awcm_pkg::AVG_DEPTH];
   logic [awcm_pkg::IDX_W-1:0]    next_slot;
   logic [awcm_pkg::ERRCNT_W-1:0] flagged_total;
   logic [awcm_pkg::WIN_W-1:0]    short_len;
   logic [awcm_pkg::WIN_W-1:0]    long_len;

   current_reading_type pending_readings [$];

   int  samples_sent     = 0;
   int  readings_checked = 0;
   int  csr_writes       = 0;
   int  full_edges       = 0;
   int  error_total      = 0;
   int  cycle_count      = 0;
   bit  push_live        = 1'b0;
   bit  csr_live         = 1'b0;
   bit  tx_burst         = 1'b0;
   bit  rx_burst         = 1'b0;
   bit  rx_hold_req      = 1'b0;

   // directed rows: after reset, field extremes, window clamping, spare indexes
   stim_row_type script [SCRIPT_LEN] = '{
      '{ROW_SAMPLE, awcm_pkg::CSR_SHORT_WINDOW, 16'h0000, 1'b1, '{12'd0, 12'd0, 32'd0}},
      '{ROW_SAMPLE, awcm_pkg::CSR_SHORT_WINDOW, 16'h8000, 1'b1, '{12'd0, 12'd0, 32'd1}},
      '{ROW_WRITE,  awcm_pkg::CSR_SHORT_WINDOW, 16'd1,    1'b0, NO_READING},
      '{ROW_WRITE,  awcm_pkg::CSR_LONG_WINDOW,  16'd1,    1'b0, NO_READING},
      '{ROW_SAMPLE, awcm_pkg::CSR_SHORT_WINDOW, 16'h0FFF, 1'b1, '{12'd2999, 12'd2999, 32'd1}},
      '{ROW_SAMPLE, awcm_pkg::CSR_SHORT_WINDOW, 16'h7FFF, 1'b1, '{12'd2999, 12'd2999, 32'd1}},
      '{ROW_SAMPLE, awcm_pkg::CSR_SHORT_WINDOW, 16'hFFFF, 1'b1, '{12'd2999, 12'd2999, 32'd2}},
      '{ROW_SAMPLE, awcm_pkg::CSR_SHORT_WINDOW, 16'hF000, 1'b1, '{12'd0, 12'd0, 32'd3}},
      '{ROW_WRITE,  awcm_pkg::CSR_SHORT_WINDOW, 16'd0,    1'b0, NO_READING},
      '{ROW_WRITE,  awcm_pkg::CSR_LONG_WINDOW,  16'd127,  1'b0, NO_READING},
      '{ROW_SAMPLE, awcm_pkg::CSR_SHORT_WINDOW, 16'h0FFF, 1'b0, NO_READING},
      '{ROW_SAMPLE, awcm_pkg::CSR_SHORT_WINDOW, 16'h0ABC, 1'b0, NO_READING},
      '{ROW_WRITE,  awcm_pkg::CSR_SHORT_WINDOW, 16'd64,   1'b0, NO_READING},
      '{ROW_WRITE,  awcm_pkg::CSR_LONG_WINDOW,  16'd65,   1'b0, NO_READING},
      '{ROW_SAMPLE, awcm_pkg::CSR_SHORT_WINDOW, 16'h0001, 1'b0, NO_READING},
      '{ROW_SAMPLE, awcm_pkg::CSR_SHORT_WINDOW, 16'h0800, 1'b0, NO_READING},
      '{ROW_SAMPLE, awcm_pkg::CSR_SHORT_WINDOW, 16'h8FFF, 1'b0, NO_READING},
      '{ROW_WRITE,  CSR_SPARE_2,                16'h0055, 1'b0, NO_READING},
      '{ROW_WRITE,  CSR_SPARE_3,                16'h002A, 1'b0, NO_READING},
      '{ROW_SAMPLE, awcm_pkg::CSR_SHORT_WINDOW, 16'h5555, 1'b0, NO_READING},
      '{ROW_SAMPLE, awcm_pkg::CSR_SHORT_WINDOW, 16'hAAAA, 1'b0, NO_READING},
      '{ROW_WRITE,  awcm_pkg::CSR_SHORT_WINDOW, 16'd8,    1'b0, NO_READING},
      '{ROW_WRITE,  awcm_pkg::CSR_LONG_WINDOW,  16'd64,   1'b0, NO_READING},
      '{ROW_SAMPLE, awcm_pkg::CSR_SHORT_WINDOW, 16'h1234, 1'b0, NO_READING},
      '{ROW_SAMPLE, awcm_pkg::CSR_SHORT_WINDOW, 16'h0FFF, 1'b0, NO_READING}
   };

   // rounded mean of the newest samples, zero window as one, long as the ring
   function automatic int unsigned window_mean(input logic [awcm_pkg::WIN_W-1:0] w);
      int unsigned span;
      int unsigned total;
      int          slot;
      span = (w == '0) ? 1 :
             ((int'(w) > awcm_pkg::AVG_DEPTH) ? awcm_pkg::AVG_DEPTH : int'(w));
      total = 0;
      for (int j = 0; j < span; j++) begin
         slot = (int'(next_slot) - 1 - j + 2 * awcm_pkg::AVG_DEPTH) % awcm_pkg::AVG_DEPTH;
         total += ring_model[slot];
      end
      return (total + span / 2) / span;
   endfunction

   function automatic logic [awcm_pkg::MA_W-1:0] to_milliamps(input int unsigned raw);
      longint unsigned mv;
      longint unsigned ma;
      mv = (64'(raw) * awcm_pkg::REF_MV + (1 << (awcm_pkg::RAW_SHIFT - 1)))
           >> awcm_pkg::RAW_SHIFT;
      ma = (mv * awcm_pkg::MA_MUL + (1 << (awcm_pkg::MA_SHIFT - 1))) >> awcm_pkg::MA_SHIFT;
      return awcm_pkg::MA_W'(ma);
   endfunction

   // store one sample and return the reading it produces
   function automatic current_reading_type absorb_sample(
      input logic [awcm_pkg::WORD_W-1:0] word);
      current_reading_type r;
      if (word[awcm_pkg::ERR_BIT]) begin
         flagged_total = flagged_total + 1'b1;
      end
      ring_model[next_slot] = word[awcm_pkg::SAMPLE_W-1:0];
      next_slot = next_slot + 1'b1;
      r.short_current = to_milliamps(window_mean(short_len));
      r.long_current  = to_milliamps(window_mean(long_len));
      r.errors        = flagged_total;
      return r;
   endfunction

   function automatic logic [awcm_pkg::WIN_W-1:0] pick_window();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return awcm_pkg::WIN_W'(1);
         2: return awcm_pkg::WIN_W'(awcm_pkg::AVG_DEPTH);
         3: return '1;
         4: return awcm_pkg::WIN_W'($urandom_range(awcm_pkg::AVG_DEPTH + 1, 126));
         default: return awcm_pkg::WIN_W'($urandom_range(2, awcm_pkg::AVG_DEPTH - 1));
      endcase
   endfunction

   // mostly a noisy steady level, with full-range words and rail values mixed in
   function automatic logic [awcm_pkg::WORD_W-1:0] make_word(input int level);
      logic [awcm_pkg::WORD_W-1:0] w;
      int                          v;
      w = awcm_pkg::WORD_W'($urandom);
      case ($urandom_range(0, 7))
         0, 1: begin
         end
         2: begin
            w[awcm_pkg::SAMPLE_W-1:0] = $urandom_range(0, 1) ? '1 : '0;
         end
         default: begin
            v = level + $urandom_range(0, 64) - 32;
            if (v < 0) v = 0;
            if (v > (1 << awcm_pkg::SAMPLE_W) - 1) v = (1 << awcm_pkg::SAMPLE_W) - 1;
            w[awcm_pkg::SAMPLE_W-1:0] = awcm_pkg::SAMPLE_W'(v);
            w[awcm_pkg::ERR_BIT] = ($urandom_range(0, 7) == 0);
         end
      endcase
      return w;
   endfunction

   task automatic write_csr(input logic [awcm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [awcm_pkg::WIN_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      csr_live = 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_writes++;
      if (idx == awcm_pkg::CSR_SHORT_WINDOW) begin
         short_len = val;
      end else if (idx == awcm_pkg::CSR_LONG_WINDOW) begin
         long_len = val;
      end
   endtask

   task automatic send_sample(input logic [awcm_pkg::WORD_W-1:0] word, input logic typed,
                              input current_reading_type want);
      int                  gap;
      current_reading_type predicted;
      if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
      gap = tx_burst ? 0 : $urandom_range(0, 7);
      if (csr_live) begin
         csr_valid <= 1'b0;
         csr_live = 1'b0;
      end
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push        <= 1'b1;
      req_sample_word <= word;
      push_live = 1'b1;
      do begin
         @(posedge clock);
         if (req_full) full_edges++;
      end while (req_full);
      predicted = absorb_sample(word);
      pending_readings.push_back(typed ? want : predicted);
      samples_sent++;
   endtask

   // drop the request line and hold until every reading has come back
   task automatic drain_readings();
      if (push_live) begin
         req_push <= 1'b0;
         push_live = 1'b0;
      end
      while (pending_readings.size() != 0) @(posedge clock);
   endtask

   task automatic note_mismatch(input string field, input longint unsigned want,
                                input longint unsigned got);
      error_total++;
      if (error_total <= REPORT_LIMIT) begin
         $display("mismatch in %s of reading %0d: expected %0d, got %0d",
                  field, readings_checked, want, got);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d readings outstanding",
                  cycle_count, pending_readings.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : reading_sink
      current_reading_type want;
      int                  gap;
      wait (reset == 1'b0);
      forever begin
         if (rx_hold_req) begin
            rsp_pop <= 1'b0;
            repeat (RX_HOLD_CYCLES) @(posedge clock);
            rx_hold_req = 1'b0;
         end
         if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
         gap = rx_burst ? 0 : $urandom_range(0, 7);
         if (gap != 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         readings_checked++;
         if (pending_readings.size() == 0) begin
            error_total++;
            if (error_total <= REPORT_LIMIT) begin
               $display("unexpected reading %0d: short %0d, long %0d, errors %0d",
                        readings_checked, rsp_short_milliamps, rsp_long_milliamps,
                        rsp_error_count);
            end
         end else begin
            want = pending_readings.pop_front();
            if (rsp_short_milliamps !== want.short_current)
               note_mismatch("short_milliamps", want.short_current, rsp_short_milliamps);
            if (rsp_long_milliamps !== want.long_current)
               note_mismatch("long_milliamps", want.long_current, rsp_long_milliamps);
            if (rsp_error_count !== want.errors)
               note_mismatch("error_count", want.errors, rsp_error_count);
         end
      end
   end

   initial begin : sample_source
      int phase_level;
      for (int i = 0; i < awcm_pkg::AVG_DEPTH; i++) ring_model[i] = '0;
      next_slot     = '0;
      flagged_total = '0;
      short_len     = awcm_pkg::SHORT_WIN_RESET;
      long_len      = awcm_pkg::LONG_WIN_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (script[r]) begin
         if (script[r].kind == ROW_WRITE) begin
            drain_readings();
            write_csr(script[r].index, script[r].value[awcm_pkg::WIN_W-1:0]);
         end else begin
            send_sample(script[r].value, script[r].typed, script[r].want);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_readings();
         write_csr(awcm_pkg::CSR_SHORT_WINDOW, pick_window());
         write_csr(awcm_pkg::CSR_LONG_WINDOW, pick_window());
         if ($urandom_range(0, 3) == 0) begin
            write_csr($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3,
                      awcm_pkg::WIN_W'($urandom));
         end
         // stall the reading side long enough for the input queue to fill
         if (phase == HOLD_PHASE) rx_hold_req = 1'b1;
         phase_level = $urandom_range(0, (1 << awcm_pkg::SAMPLE_W) - 1);
         repeat (PHASE_SAMPLES) send_sample(make_word(phase_level), 1'b0, NO_READING);
      end

      drain_readings();
      repeat (2 * MAX_LATENCY) @(posedge clock);

      $display("Run: %0d samples, %0d readings, %0d register writes in %0d window phases.",
               samples_sent, readings_checked, csr_writes, RANDOM_PHASES + SCRIPT_PHASES);
      $display("Input held off on %0d edges; error count ended at %0d.",
               full_edges, flagged_total);
      if (error_total == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
